// ===== src/dhc_pkg.sv =====
// Package for the debug halt controller: command and response beat types,
// command codes and status codes. It depends on nothing else.
`default_nettype none

package dhc_pkg;

  // Command codes carried in the command field of a request beat.
  localparam logic [2:0] CMD_CHECK      = 3'd0;
  localparam logic [2:0] CMD_RUN        = 3'd1;
  localparam logic [2:0] CMD_STEP       = 3'd2;
  localparam logic [2:0] CMD_UNTIL      = 3'd3;
  localparam logic [2:0] CMD_ADD_BREAK  = 3'd4;
  localparam logic [2:0] CMD_DROP_BREAK = 3'd5;

  // Status codes returned with every response beat.
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_TABLE_FULL = 2'd1;
  localparam logic [1:0] STATUS_DROP_UNUSED = 2'd2;

  // One request beat.
  typedef struct packed {
    logic [2:0]  command;
    logic [63:0] address;
    logic [31:0] step_count;
    logic [3:0]  break_index;
  } cmd_t;

  // One response beat.
  typedef struct packed {
    logic        halted;
    logic [63:0] halt_address;
    logic [3:0]  assigned_index;
    logic [1:0]  status;
  } rsp_t;

endpackage

`default_nettype wire

// ===== src/debug_halt_controller.sv =====
// Debug halt controller: breakpoint table, step counter and run-until target
// that decide for each executed address whether the processor halts.
// Depends on dhc_pkg for the beat types and the command and status codes.
//
//   channel   ports                     handshake
//   --------  ------------------------  ---------------------------------------
//   command   start_i, busy_o, cmd_i    beat taken at a rising edge, start_i & ~busy_o
//   response  rsp_valid_o, rsp_o        strobe high one cycle, beat taken at its end
//
// Every command beat gives one response beat: the command passes the input
// register, then the decision logic (the parallel address compare over all
// breakpoint slots), then the response register.
// A new command is taken in every cycle; busy_o stays low.
// Reset is asynchronous and active low; it clears the mode, the skip flag, the
// counters and the slot valid and armed bits. The receiver cannot stall.
`default_nettype none

module debug_halt_controller
  import dhc_pkg::*;
#(
  parameter int BREAK_SLOTS = 16,
  parameter int ADDR_BITS   = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  output logic      busy_o,
  input  wire cmd_t cmd_i,
  output logic      rsp_valid_o,
  output rsp_t      rsp_o
);

  localparam int CNT_W = $clog2(BREAK_SLOTS + 1);

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_RUN   = 4'b0010,
    MODE_STEP  = 4'b0100,
    MODE_UNTIL = 4'b1000
  } mode_e;

  // Input register.
  logic             in_valid_q;
  cmd_t             in_q;

  // Controller state.
  mode_e            mode_q, mode_d;
  logic             skip_q, skip_d;
  logic [31:0]      steps_q, steps_d;
  logic [ADDR_BITS-1:0] target_q, target_d;
  logic [ADDR_BITS-1:0] baddr_q [BREAK_SLOTS];
  logic [BREAK_SLOTS-1:0] bused_q, bused_d;
  logic [BREAK_SLOTS-1:0] barmed_q, barmed_d;
  logic [CNT_W-1:0] next_slot_q, next_slot_d;

  // Response register.
  logic             rsp_valid_q;
  rsp_t             rsp_q, rsp_d;

  // Decision signals.
  logic [ADDR_BITS-1:0]   addr;
  logic [BREAK_SLOTS-1:0] match;
  logic [BREAK_SLOTS-1:0] sel;
  logic [BREAK_SLOTS-1:0] same_gone;
  logic [BREAK_SLOTS-1:0] wr_en;
  logic [ADDR_BITS-1:0]   gone_addr;
  logic                   hit;
  logic                   drop_ok;
  logic                   table_full;
  logic                   stop;

  assign busy_o = 1'b0;
  assign addr   = in_q.address[ADDR_BITS-1:0];

  // Capture each command beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      in_q <= cmd_i;
    end
  end

  // Parallel compares against every slot: the executed address for a check,
  // the slot chosen by the drop index and the address that slot holds.
  always_comb begin
    gone_addr = '0;
    for (int i = 0; i < BREAK_SLOTS; i++) begin
      match[i]  = (baddr_q[i] == addr);
      sel[i]    = (32'(in_q.break_index) == i);
      gone_addr = gone_addr | ({ADDR_BITS{sel[i]}} & baddr_q[i]);
    end
    for (int i = 0; i < BREAK_SLOTS; i++) begin
      same_gone[i] = bused_q[i] && (baddr_q[i] == gone_addr);
    end
    hit        = |(bused_q & barmed_q & match);
    drop_ok    = |(sel & bused_q);
    table_full = (next_slot_q >= CNT_W'(BREAK_SLOTS));
  end

  // Halt decision for a check.
  always_comb begin
    if (!skip_q && hit) begin
      stop = 1'b1;
    end else begin
      case (mode_q)
        MODE_RUN:   stop = 1'b0;
        MODE_STEP:  stop = (steps_q == '0);
        MODE_UNTIL: stop = (addr == target_q) && !skip_q;
        default:    stop = 1'b1;
      endcase
    end
  end

  // Next state and response for the registered command.
  always_comb begin
    mode_d      = mode_q;
    skip_d      = skip_q;
    steps_d     = steps_q;
    target_d    = target_q;
    bused_d     = bused_q;
    barmed_d    = barmed_q;
    next_slot_d = next_slot_q;
    wr_en       = '0;
    rsp_d       = '0;
    if (in_valid_q) begin
      case (in_q.command)
        CMD_CHECK: begin
          skip_d = 1'b0;
          if (stop) begin
            mode_d             = MODE_IDLE;
            rsp_d.halted       = 1'b1;
            rsp_d.halt_address = 64'(addr);
          end else if (!(!skip_q && hit) && mode_q == MODE_STEP) begin
            steps_d = steps_q - 32'd1;
          end
        end
        CMD_RUN: begin
          mode_d = MODE_RUN;
          skip_d = 1'b1;
        end
        CMD_STEP: begin
          mode_d  = MODE_STEP;
          skip_d  = 1'b1;
          steps_d = in_q.step_count;
        end
        CMD_UNTIL: begin
          mode_d   = MODE_UNTIL;
          skip_d   = 1'b1;
          target_d = addr;
        end
        CMD_ADD_BREAK: begin
          if (table_full) begin
            rsp_d.status = STATUS_TABLE_FULL;
          end else begin
            for (int i = 0; i < BREAK_SLOTS; i++) begin
              wr_en[i] = (next_slot_q == CNT_W'(i));
            end
            bused_d              = bused_q | wr_en;
            barmed_d             = barmed_q | wr_en;
            rsp_d.assigned_index = 4'(next_slot_q);
            next_slot_d          = next_slot_q + CNT_W'(1);
          end
        end
        CMD_DROP_BREAK: begin
          if (!drop_ok) begin
            rsp_d.status = STATUS_DROP_UNUSED;
          end else begin
            barmed_d = barmed_q & ~same_gone;
            bused_d  = bused_q & ~sel;
          end
        end
        default: begin
          rsp_d = '0;
        end
      endcase
    end
  end

  // Control state and response strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      skip_q      <= 1'b0;
      steps_q     <= '0;
      target_q    <= '0;
      bused_q     <= '0;
      barmed_q    <= '0;
      next_slot_q <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      skip_q      <= skip_d;
      steps_q     <= steps_d;
      target_q    <= target_d;
      bused_q     <= bused_d;
      barmed_q    <= barmed_d;
      next_slot_q <= next_slot_d;
      rsp_valid_q <= in_valid_q;
    end
  end

  // Response payload.
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  // Breakpoint addresses; an entry is only read while its slot is in use.
  for (genvar g = 0; g < BREAK_SLOTS; g++) begin : g_slot
    always_ff @(posedge clk_i) begin
      if (wr_en[g]) begin
        baddr_q[g] <= addr;
      end
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // Every command beat is followed by a response beat, through the input and response registers.
  a_one_rsp_per_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 rsp_valid_o)
    else $error("command beat without response beat");

  // A halt leaves the controller idle.
  a_halt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.halted) |-> (mode_q == MODE_IDLE))
    else $error("halt did not return the mode to idle");

  // A halt never carries an error status.
  a_halt_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.halted) |-> (rsp_o.status == STATUS_OK))
    else $error("halt response with error status");

  // The slot counter never passes the table size.
  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_slot_q <= CNT_W'(BREAK_SLOTS))
    else $error("slot counter beyond table size");

endmodule

`default_nettype wire
